// ===== rtl/project_point_to_screen_top_assert.svh =====
// Assertion macros for the point projection RTL.
`ifndef PROJECT_POINT_TO_SCREEN_TOP_ASSERT_SVH
`define PROJECT_POINT_TO_SCREEN_TOP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define PPTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppts assertion failed");

// Condition must hold in the cycle after the trigger
`define PPTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppts assertion failed");

`endif

// ===== rtl/ppts_pkg.sv =====
// Package: widths, constants and register codes of the point projection block.
`timescale 1ns / 1ps
`default_nettype none
package ppts_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int CLIP_W    = PROD_W - FRAC_BITS + 2;
  localparam int MAG_W     = CLIP_W;
  localparam int DEN_W     = CLIP_W + 1;
  localparam int DIM_W     = 14;
  localparam int K_W       = DIM_W + FRAC_BITS;
  localparam int NUM_W     = MAG_W + K_W;
  localparam int SPLIT_W   = MAG_W / 2;
  localparam int PART_W    = (MAG_W - SPLIT_W) + K_W;
  localparam int QB        = COORD_W - 1;
  localparam int CMP_W     = DEN_W + QB + 1;
  localparam int NEAR_Q    = ((1 << FRAC_BITS) + 5) / 10;
  localparam int REG_W     = 64;
  localparam int ADDR_W    = 6;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);

  typedef enum logic [2:0] {
    REG_X_LO = 3'd0, REG_X_HI = 3'd1, REG_Y_LO = 3'd2, REG_Y_HI = 3'd3,
    REG_W_LO = 3'd4, REG_W_HI = 3'd5, REG_WIDTH = 3'd6, REG_HEIGHT = 3'd7
  } reg_idx_e;
endpackage
`default_nettype wire

// ===== rtl/ppts_div.sv =====
// Pipelined restoring divider with saturation to a signed 32-bit result.
`timescale 1ns / 1ps
`default_nettype none
module ppts_div (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire  [ppts_pkg::NUM_W-1:0]    num_i,
  input  wire  [ppts_pkg::DEN_W-1:0]    den_i,
  input  wire                           neg_i,
  output logic [ppts_pkg::COORD_W-1:0]  res_o
);
  import ppts_pkg::*;

  logic [NUM_W-1:0] rem_q [QB+1];
  logic [DEN_W-1:0] den_q [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic             neg_q [QB+1];
  logic             sat_q [QB+1];

  // First stage: overflow check against den * 2^31
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      quo_q[0] <= '0;
      sat_q[0] <= CMP_W'(num_i) >= (CMP_W'(den_i) << QB);
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= QB; j++) begin : g_bit
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] remx;
    logic             ge;
    assign trial = CMP_W'(den_q[j-1]) << (QB - j);
    assign remx  = CMP_W'(rem_q[j-1]);
    assign ge    = remx >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? NUM_W'(remx - trial) : rem_q[j-1];
        den_q[j] <= den_q[j-1];
        neg_q[j] <= neg_q[j-1];
        sat_q[j] <= sat_q[j-1];
        quo_q[j] <= quo_q[j-1] | (ge ? (QB'(1) << (QB - j)) : '0);
      end
    end
  end

  // Sign and saturation
  always_comb begin
    if (sat_q[QB]) begin
      res_o = neg_q[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else if (neg_q[QB]) begin
      res_o = COORD_W'(0) - {1'b0, quo_q[QB]};
    end else begin
      res_o = {1'b0, quo_q[QB]};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/project_point_to_screen_top.sv =====
// Top level: world point to screen pixel projection pipeline with APB registers.
`timescale 1ns / 1ps
`default_nettype none
// Projects one Q16.16 world point per cycle through rows 0, 1 and 3 of the
// view-projection matrix, tests clip w against 0.1 and maps x/w and y/w to
// saturated Q16.16 pixel coordinates. Throughput is one item per cycle while
// the output is taken; an item passes 38 register stages from input to output
// register: one multiply stage, one sum stage, one sign/denominator stage, two
// stages of numerator multiply and 32 stages of the bit-per-stage divider, plus
// the output register. The whole pipeline holds when the output item is not
// taken. Registers sit at byte address 8*i; the user must write them only while
// no item is in flight, and the block itself does not enforce this.
module project_point_to_screen_top (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire  [95:0]               s_axis_tdata_i,  // world_x, world_y, world_z
  output logic                      m_axis_tvalid_o,
  input  wire                       m_axis_tready_i,
  output logic [63:0]               m_axis_tdata_o,  // screen_x, screen_y
  output logic                      m_axis_tuser_o,  // visible
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [ppts_pkg::ADDR_W-1:0] paddr,
  input  wire  [ppts_pkg::REG_W-1:0]  pwdata,
  output logic [ppts_pkg::REG_W-1:0]  prdata,
  output logic                      pready
);
  import ppts_pkg::*;

  `include "project_point_to_screen_top_assert.svh"

  logic [REG_W-1:0] row_q [6];
  logic [DIM_W-1:0] width_q, height_q;
  reg_idx_e         widx;
  logic             adv;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[5:3]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) row_q[i] <= '0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default:    row_q[widx] <= pwdata;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (widx)
      REG_WIDTH:  prdata = REG_W'(width_q);
      REG_HEIGHT: prdata = REG_W'(height_q);
      default:    prdata = row_q[widx];
    endcase
  end

  // Matrix entries by row and column
  logic signed [COORD_W-1:0] mat   [3][4];
  logic signed [COORD_W-1:0] coord [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = row_q[2*r + c/2][(c%2)*COORD_W +: COORD_W];
      end
    end
    for (int c = 0; c < 3; c++) coord[c] = s_axis_tdata_i[c*COORD_W +: COORD_W];
  end

  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  logic                      v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                      vis3_q, vis4_q, vis5_q;
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [CLIP_W-1:0]  clip_q [3];
  logic [MAG_W-1:0]          mag_q  [2];
  logic                      neg3_q [2], neg4_q [2], neg5_q [2];
  logic [DEN_W-1:0]          den3_q, den4_q, den5_q;
  logic [PART_W-1:0]         plo_q  [2], phi_q [2];
  logic [NUM_W-1:0]          num_q  [2];
  logic                      dv_q   [QB+1];
  logic                      dvis_q [QB+1];
  logic [COORD_W-1:0]        res    [2];
  logic signed [CLIP_W-1:0]  cw, lane_a [2];
  logic [K_W-1:0]            kdim   [2];

  assign cw        = clip_q[2];
  assign lane_a[0] = clip_q[0] + cw;
  assign lane_a[1] = cw - clip_q[1];
  assign kdim[0]   = {width_q, {FRAC_BITS{1'b0}}};
  assign kdim[1]   = {height_q, {FRAC_BITS{1'b0}}};

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q} <= '0;
      for (int i = 0; i <= QB; i++) dv_q[i] <= 1'b0;
      m_axis_tvalid_o <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      dv_q[0] <= v5_q;
      for (int i = 1; i <= QB; i++) dv_q[i] <= dv_q[i-1];
      m_axis_tvalid_o <= dv_q[QB];
    end
  end

  // Data path stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // products of coordinate and matrix entry
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= PROD_W'(coord[c]) * PROD_W'(mat[r][c]);
        end
      end
      // clip coordinates, products floored to the fixed-point grid
      for (int r = 0; r < 3; r++) begin
        clip_q[r] <= CLIP_W'(prod_q[r][0] >>> FRAC_BITS) +
                     CLIP_W'(prod_q[r][1] >>> FRAC_BITS) +
                     CLIP_W'(prod_q[r][2] >>> FRAC_BITS) + CLIP_W'(mat[r][3]);
      end
      // near test, magnitudes and denominator
      vis3_q <= cw >= CLIP_W'(NEAR_Q);
      den3_q <= {cw, 1'b0};
      for (int l = 0; l < 2; l++) begin
        neg3_q[l] <= lane_a[l][CLIP_W-1];
        mag_q[l]  <= lane_a[l][CLIP_W-1] ? MAG_W'(-lane_a[l]) : MAG_W'(lane_a[l]);
      end
      // numerator partial products
      vis4_q <= vis3_q;
      den4_q <= den3_q;
      for (int l = 0; l < 2; l++) begin
        neg4_q[l] <= neg3_q[l];
        plo_q[l]  <= PART_W'(mag_q[l][SPLIT_W-1:0]) * PART_W'(kdim[l]);
        phi_q[l]  <= PART_W'(mag_q[l][MAG_W-1:SPLIT_W]) * PART_W'(kdim[l]);
      end
      // numerator sum
      vis5_q <= vis4_q;
      den5_q <= den4_q;
      for (int l = 0; l < 2; l++) begin
        neg5_q[l] <= neg4_q[l];
        num_q[l]  <= (NUM_W'(phi_q[l]) << SPLIT_W) + NUM_W'(plo_q[l]);
      end
      // visibility alongside the divider
      dvis_q[0] <= vis5_q;
      for (int i = 1; i <= QB; i++) dvis_q[i] <= dvis_q[i-1];
      // output register
      m_axis_tuser_o <= dvis_q[QB];
      m_axis_tdata_o <= dvis_q[QB] ? {res[1], res[0]} : '0;
    end
  end

  // Divider per screen axis
  for (genvar l = 0; l < 2; l++) begin : g_lane
    ppts_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[l]),
      .den_i (den5_q),
      .neg_i (neg5_q[l]),
      .res_o (res[l])
    );
  end

  `PPTS_ASSERT_NOW(a_hidden_zero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == 64'd0)
  `PPTS_ASSERT_NOW(a_stall_blocks, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o)
  `PPTS_ASSERT_NEXT(a_enter, s_axis_tvalid_i && s_axis_tready_o, v1_q)
endmodule
`default_nettype wire

// ===== tb/tb_project_point_to_screen_top.sv =====
// Testbench for the point projection block: random and directed points, scoreboard check.
`timescale 1ns / 1ps
module tb_project_point_to_screen_top;
  import ppts_pkg::*;

  typedef struct packed {
    logic        visible;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
  } pixel_t;

  // Expected-pixel store with its own copy of the matrix rows and viewport size
  class pixel_scoreboard;
    logic [63:0]      row_q[6];
    logic [DIM_W-1:0] vp_width;
    logic [DIM_W-1:0] vp_height;
    pixel_t           pixel_q[$];

    function new();
      foreach (row_q[i]) row_q[i] = '0;
      vp_width  = WIDTH_RST;
      vp_height = HEIGHT_RST;
    endfunction

    function void write_reg(reg_idx_e idx, logic [63:0] val);
      case (idx)
        REG_WIDTH:  vp_width  = val[DIM_W-1:0];
        REG_HEIGHT: vp_height = val[DIM_W-1:0];
        default:    row_q[idx] = val;
      endcase
    endfunction

    // floor-shifted dot product of one matrix row with (x, y, z, 1)
    function longint row_dot(logic [63:0] lo, logic [63:0] hi, longint x, longint y,
                             longint z);
      longint m0, m1, m2, m3;
      m0 = longint'($signed(lo[31:0]));
      m1 = longint'($signed(lo[63:32]));
      m2 = longint'($signed(hi[31:0]));
      m3 = longint'($signed(hi[63:32]));
      return ((x * m0) >>> FRAC_BITS) + ((y * m1) >>> FRAC_BITS) +
             ((z * m2) >>> FRAC_BITS) + m3;
    endfunction

    // dim * 2^F * a / (2 * cw), truncated toward zero, saturated to 32 bits
    function logic [31:0] viewport(longint a, logic [DIM_W-1:0] dim, longint cw);
      logic signed [127:0] num, den, quo;
      num = 128'(signed'(a)) * $signed({96'd0, 18'd0, dim} << FRAC_BITS);
      den = 128'(signed'(cw)) * 2;
      quo = num / den;
      if (quo > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (quo < -128'sh8000_0000) return 32'h8000_0000;
      return quo[31:0];
    endfunction

    function void note_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
      longint x, y, z, cx, cy, cw;
      pixel_t p;
      x  = longint'($signed(wx));
      y  = longint'($signed(wy));
      z  = longint'($signed(wz));
      cx = row_dot(row_q[REG_X_LO], row_q[REG_X_HI], x, y, z);
      cy = row_dot(row_q[REG_Y_LO], row_q[REG_Y_HI], x, y, z);
      cw = row_dot(row_q[REG_W_LO], row_q[REG_W_HI], x, y, z);
      p = '0;
      if (cw >= NEAR_Q) begin
        p.visible  = 1'b1;
        p.screen_x = viewport(cx + cw, vp_width, cw);
        p.screen_y = viewport(cw - cy, vp_height, cw);
      end
      pixel_q.push_back(p);
    endfunction

    // returns a non-empty message on mismatch
    function string check_pixel(pixel_t got);
      pixel_t exp_p;
      if (pixel_q.size() == 0) return $sformatf("unexpected pixel %p", got);
      exp_p = pixel_q.pop_front();
      if (got.visible !== exp_p.visible)
        return $sformatf("visible %0b, expected %0b", got.visible, exp_p.visible);
      if (got.screen_x !== exp_p.screen_x)
        return $sformatf("screen_x %h, expected %h", got.screen_x, exp_p.screen_x);
      if (got.screen_y !== exp_p.screen_y)
        return $sformatf("screen_y %h, expected %h", got.screen_y, exp_p.screen_y);
      return "";
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [95:0]       s_axis_tdata_i = '0;  // world_x, world_y, world_z
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [63:0]       m_axis_tdata_o;       // screen_x, screen_y
  logic              m_axis_tuser_o;       // visible
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0]  pwdata = '0;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  pixel_scoreboard sb = new();
  int              fail_cnt = 0;
  int              burst_left = 0;

  project_point_to_screen_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // Register write: setup cycle, then access cycle
  task automatic reg_write(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [63:0] pack_row(logic [31:0] a, logic [31:0] b);
    return {b, a};
  endfunction

  // Send one point; sender runs in bursts with random gaps
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_point(x, y, z);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // Wait until the pipeline has drained before touching registers
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] small_q(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      default: return small_q(32'h0040_0000);
    endcase
  endfunction

  // Random matrix: mostly moderate entries, sometimes full range
  task automatic random_matrix(bit wide);
    for (int r = 0; r < 6; r++) begin
      logic [31:0] a, b;
      a = wide ? $urandom() : small_q(32'h0003_0000);
      b = wide ? $urandom() : small_q(32'h0003_0000);
      if (r == REG_W_HI && !wide) b = 32'($urandom_range(0, 32'h0010_0000));
      reg_write(reg_idx_e'(r), pack_row(a, b));
    end
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) send_point(any_coord(), any_coord(), any_coord());
  endtask

  // Receiver stalls in runs: always ready, mostly short stalls, random
  always @(posedge clk_i) begin
    case (($time / 2000) % 3)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready_i <= ($urandom_range(0, 1) != 0);
    endcase
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      string msg;
      msg = sb.check_pixel({m_axis_tuser_o, m_axis_tdata_o[31:0], m_axis_tdata_o[63:32]});
      if (msg != "") report(msg);
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset matrix is zero: every point falls behind the near plane
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    drain();

    // simple perspective: clip w equals z
    reg_write(REG_X_LO, pack_row(32'h0001_0000, 32'h0));
    reg_write(REG_X_HI, pack_row(32'h0, 32'h0));
    reg_write(REG_Y_LO, pack_row(32'h0, 32'h0001_0000));
    reg_write(REG_Y_HI, pack_row(32'h0, 32'h0));
    reg_write(REG_W_LO, pack_row(32'h0, 32'h0));
    reg_write(REG_W_HI, pack_row(32'h0001_0000, 32'h0));
    send_point(32'h0, 32'h0, 32'(NEAR_Q - 1));              // just behind near plane
    send_point(32'h0, 32'h0, 32'(NEAR_Q));                  // exactly on near plane
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'(NEAR_Q));  // saturating both ways
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'(NEAR_Q));
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h0, 32'h0, 32'h8000_0000);                // negative w
    send_point(32'h1234_5678, 32'hDEAD_BEEF, 32'h0002_0000);
    random_points(150);
    drain();

    // zero viewport, masking of upper register bits, maximum viewport
    reg_write(REG_WIDTH, 64'hFFFF_FFFF_FFFF_C000);
    reg_write(REG_HEIGHT, 64'h0000_0000_0000_3FFF);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_2000);
    random_points(150);
    drain();
    reg_write(REG_WIDTH, 64'd1);
    reg_write(REG_HEIGHT, 64'd8192);
    random_points(150);
    drain();

    // extreme matrix entries
    for (int r = 0; r < 6; r++)
      reg_write(reg_idx_e'(r), pack_row(32'h8000_0000, 32'h7FFF_FFFF));
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_points(100);
    drain();

    // random matrices and viewports
    for (int ph = 0; ph < 6; ph++) begin
      random_matrix(ph == 5);
      reg_write(REG_WIDTH, 64'($urandom_range(0, 16383)));
      reg_write(REG_HEIGHT, 64'($urandom_range(1, 8192)));
      random_points(120);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
